// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, opcodes, status codes and the result record of the bounded
// deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   localparam int BDQ_CAPACITY = 32;

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SEARCH    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_REM_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    found_index;
      logic [COUNT_W-1:0]  element_count;
   } bdq_result_type;

endpackage

`default_nettype wire

// ----- rtl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bdq_seq.sv -----
// ----------------------------------------------------------------------------
// bdq_seq
// Request sequencer: ring pointers, entry shifting for insert before position
// and the linear search, all through one RAM read and one RAM write a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_seq #(
   parameter int CAPACITY = bdq_pkg::BDQ_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bdq_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [bdq_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [bdq_pkg::DATA_W-1:0] req_data_value,
   input  wire logic                              rsp_free,
   output bdq_pkg::bdq_result_type                result,
   output logic                                   mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]            mem_wr_addr,
   output logic [bdq_pkg::DATA_W-1:0]             mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]            mem_rd_addr,
   input  wire logic [bdq_pkg::DATA_W-1:0]        mem_rd_data
);

   import bdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_C = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_LAST,
      S_PUT,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     cur_ff, cur_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [DATA_W-1:0]    val_ff, val_in;
   logic                 pipe_ff, pipe_in;
   logic [CNT_W-1:0]     pipe_idx_ff, pipe_idx_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic [POS_W-1:0]     pend_idx_ff, pend_idx_in;

   logic                 fin_valid;
   logic [STATUS_W-1:0]  fin_status;
   logic [POS_W-1:0]     fin_idx;
   logic [COUNT_W-1:0]   idx_wide;
   logic [COUNT_W-1:0]   pos_wide;
   logic [COUNT_W-1:0]   cnt_wide;
   logic                 full;
   logic                 empty;
   logic [IDX_W-1:0]     head_dec;
   logic [IDX_W-1:0]     head_inc;

   // logical index to ring address
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] lidx);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign idx_wide  = COUNT_W'(pipe_idx_ff);
   assign pos_wide  = COUNT_W'(req_position);
   assign cnt_wide  = COUNT_W'(count_ff);
   assign full      = (count_ff == CAP_C);
   assign empty     = (count_ff == '0);
   assign head_dec  = (head_ff == '0) ? LAST_C : head_ff - 1'b1;
   assign head_inc  = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      pipe_in        = 1'b0;
      pipe_idx_in    = pipe_idx_ff;
      pend_status_in = pend_status_ff;
      pend_idx_in    = pend_idx_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = phys(head_ff, pipe_idx_ff);
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = phys(head_ff, cur_ff);
      fin_valid      = 1'b0;
      fin_status     = STAT_DONE;
      fin_idx        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_data_value;
               case (req_opcode)
                  OP_INS_FRONT: begin
                     fin_valid = 1'b1;
                     if (full) begin
                        fin_status = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = head_dec;
                        mem_wr_data = req_data_value;
                        head_in     = head_dec;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  OP_INS_AT: begin
                     if (empty && (req_position != '0)) begin
                        fin_valid  = 1'b1;
                        fin_status = STAT_EMPTY;
                     end else if (full) begin
                        fin_valid  = 1'b1;
                        fin_status = STAT_FULL;
                     end else if (pos_wide >= cnt_wide) begin
                        fin_valid  = 1'b1;
                        fin_status = STAT_BAD_POS;
                     end else begin
                        pos_in   = CNT_W'(req_position);
                        cur_in   = count_ff - 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_INS_BACK: begin
                     fin_valid = 1'b1;
                     if (full) begin
                        fin_status = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = phys(head_ff, count_ff);
                        mem_wr_data = req_data_value;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (empty) begin
                        fin_valid  = 1'b1;
                        fin_status = STAT_NOT_FOUND;
                     end else begin
                        cur_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_REM_FRONT: begin
                     fin_valid = 1'b1;
                     if (empty) begin
                        fin_status = STAT_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_REM_BACK: begin
                     fin_valid = 1'b1;
                     if (empty) begin
                        fin_status = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     fin_valid = 1'b1;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read entry cur while the previous read lands one place higher
            mem_rd_en   = 1'b1;
            mem_wr_en   = pipe_ff;
            pipe_in     = 1'b1;
            pipe_idx_in = CNT_W'(cur_ff + 1'b1);
            if (cur_ff == pos_ff) begin
               state_in = S_LAST;
            end else begin
               cur_in = cur_ff - 1'b1;
            end
         end
         S_LAST: begin
            mem_wr_en = 1'b1;
            state_in  = S_PUT;
         end
         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_ff, pos_ff);
            mem_wr_data = val_ff;
            count_in    = count_ff + 1'b1;
            fin_valid   = 1'b1;
         end
         S_SEARCH: begin
            if (pipe_ff && (mem_rd_data == val_ff)) begin
               fin_valid  = 1'b1;
               fin_status = STAT_FOUND;
               fin_idx    = idx_wide[POS_W-1:0];
            end else if (cur_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               pipe_in     = 1'b1;
               pipe_idx_in = cur_ff;
               cur_in      = CNT_W'(cur_ff + 1'b1);
            end else begin
               fin_valid  = 1'b1;
               fin_status = STAT_NOT_FOUND;
            end
         end
         S_DONE: begin
            fin_valid  = 1'b1;
            fin_status = pend_status_ff;
            fin_idx    = pend_idx_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_valid) begin
         state_in       = rsp_free ? S_IDLE : S_DONE;
         pend_status_in = fin_status;
         pend_idx_in    = fin_idx;
      end
   end

   always_comb begin
      result.valid         = fin_valid;
      result.status        = fin_status;
      result.found_index   = fin_idx;
      result.element_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pipe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pipe_ff  <= pipe_in;
      end
      cur_ff         <= cur_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      pipe_idx_ff    <= pipe_idx_in;
      pend_status_ff <= pend_status_in;
      pend_idx_ff    <= pend_idx_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("element count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_C)
      else $error("head pointer outside ring");

   a_shift_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> ((cur_ff >= pos_ff) && (cur_ff < count_ff)))
      else $error("shift cursor outside the moved range");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SEARCH) && pipe_ff) |-> (pipe_idx_ff < count_ff))
      else $error("search compared an entry beyond the count");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert before position did not grow the count");
`endif

endmodule

`default_nettype wire

// ----- rtl/bounded_deque_with_search.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded ordered list of signed 32-bit values with insert, remove and search,
// kept as a ring in one RAM, with a registered response stage.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  req_      in         valid / stall     opcode, position, data_value
//  rsp_      out        valid / stall     status, found_index, element_count
//
//  insert or remove at either end, undefined opcodes: done in the idle state
//  search: one RAM read per entry, from the front up to the first match
//  insert before position: shift, last and put states, one entry moved a cycle
//  synchronous reset empties the list at once; stored data is not cleared
//  a request is taken while a response waits; it finishes once rsp is free
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search #(
   parameter int CAPACITY = bdq_pkg::BDQ_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bdq_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [bdq_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [bdq_pkg::DATA_W-1:0] req_data_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bdq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [bdq_pkg::POS_W-1:0]              rsp_found_index,
   output logic [bdq_pkg::COUNT_W-1:0]            rsp_element_count
);

   import bdq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   bdq_result_type      result;
   logic                rsp_free;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [POS_W-1:0]    rsp_found_index_ff;
   logic [COUNT_W-1:0]  rsp_element_count_ff;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   logic [DATA_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   logic [DATA_W-1:0]   mem_rd_data;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   bdq_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_data_value (req_data_value),
      .rsp_free       (rsp_free),
      .result         (result),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= result.valid;
      end
      if (rsp_free && result.valid) begin
         rsp_status_ff        <= result.status;
         rsp_found_index_ff   <= result.found_index;
         rsp_element_count_ff <= result.element_count;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_found_index_ff;
   assign rsp_element_count = rsp_element_count_ff;

endmodule

`default_nettype wire
